@@ hdl/lzrle_pkg.sv @@
// Package for the LZ/RLE stream decompressor: decoder phase type, command codes,
// token bit positions and the widths of the decoder's counters.
// No dependencies; used by lz_rle_stream_decompressor.
package lzrle_pkg;

    // Decoder phases. The three *_EMIT phases wait for step commands.
    typedef enum logic [3:0] {
        PH_TOKEN     = 4'd0,
        PH_LIT_EXT   = 4'd1,
        PH_LIT_BYTES = 4'd2,
        PH_RUN_EXT   = 4'd3,
        PH_RUN_BYTE  = 4'd4,
        PH_RUN_EMIT  = 4'd5,
        PH_BREF_LOW  = 4'd6,
        PH_BREF_EMIT = 4'd7,
        PH_PAT_COUNT = 4'd8,
        PH_PAT_BYTES = 4'd9,
        PH_PAT_EMIT  = 4'd10
    } phase_t;

    // Command codes carried in the input sideband.
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_PUSH  = 2'd1;
    localparam logic [1:0] CMD_STEP  = 2'd2;

    // Token byte layout.
    localparam int TOK_KIND_HI = 7;
    localparam int TOK_KIND_LO = 6;
    localparam int TOK_EXT     = 5;

    // Pattern buffer: patterns are 2 to 65 bytes long.
    localparam int PAT_MAX = 65;
    localparam int PAT_AW  = 7;

    // Counter widths.
    localparam int REM_W  = 14;
    localparam int REP_W  = 9;
    localparam int PLEN_W = 7;
    localparam int DIST_W = 11;

endpackage

@@ hdl/lz_rle_stream_decompressor.sv @@
// Top level of the LZ/RLE stream decompressor: token decoder, history and
// pattern memories, and a two-entry output stage. Depends on lzrle_pkg.
//
// Usage
// -----
// The input stream carries one command per transfer: s_axis_tuser holds the
// command (start a stream, push a compressed byte, step one pending output
// byte) and s_axis_tdata holds the compressed byte for a push. Every accepted
// transfer produces exactly one result transfer on the output stream, which
// carries the decompressed byte (when one was produced) in m_axis_tdata and the
// flags out_valid, want_byte, done_res and misuse in m_axis_tuser. want_byte
// tells the source whether the next command should be a push or a step.
// The user must write the output size register through cfg_we/cfg_wdata while
// the block is idle (unenforced); decoding stops after that many bytes.
//
// Timing: one transfer is accepted per cycle while the output stage has room,
// including back to back back-references at distance one; the history memory
// is read ahead at the address the next step will need, and a write to that
// same entry is forwarded around the memory. Results are registered into the
// main output register, or into the skid entry while the main one is held, so
// the block keeps accepting while one result waits; s_axis_tready drops only
// once both are full, and it returns to high the cycle after the receiver
// takes one. Reset clears all decoder state and empties the output stage; the
// history memory is not cleared, since back-references that reach before the
// start of the stream return zero instead of reading it.
module lz_rle_stream_decompressor
    import lzrle_pkg::*;
#(
    parameter int HISTORY_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,       // output_size

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] in_byte
    input  logic [1:0]  s_axis_tuser,    // [1:0] cmd

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,    // [7:0] out_byte
    output logic [3:0]  m_axis_tuser     // [0] out_valid, [1] want_byte,
                                         // [2] done_res, [3] misuse
);

    localparam int AW  = $clog2(HISTORY_DEPTH);
    localparam int AW1 = AW + 1;
    localparam logic [AW-1:0]  LAST_POS = AW'(HISTORY_DEPTH - 1);
    localparam logic [AW1-1:0] DEPTH_W  = AW1'(HISTORY_DEPTH);

    // Decoder state.
    logic [31:0]       output_size_reg;
    logic [AW-1:0]     write_pos_reg,     write_pos_next;
    logic [AW-1:0]     rd_ptr_reg,        rd_ptr_next;
    logic [31:0]       emitted_reg,       emitted_next;
    phase_t            phase_reg,         phase_next;
    logic [7:0]        token_reg,         token_next;
    logic [REM_W-1:0]  remaining_reg,     remaining_next;
    logic [REP_W-1:0]  repeats_reg,       repeats_next;
    logic [PLEN_W-1:0] pat_len_reg,       pat_len_next;
    logic [DIST_W-1:0] distance_reg,      distance_next;
    logic [7:0]        run_byte_reg,      run_byte_next;
    logic [PAT_AW-1:0] pat_pos_reg,       pat_pos_next;

    // Memories and their read ports.
    logic [7:0] hist_mem [HISTORY_DEPTH];
    logic [7:0] pat_mem  [PAT_MAX];
    logic [7:0] hist_rdata_reg;
    logic [7:0] hist_fwd_data_reg;
    logic       hist_fwd_hit_reg;
    logic [7:0] pat_rdata_reg;
    logic [7:0] hist_rd;
    logic       hist_we;
    logic [7:0] hist_wdata;
    logic       pat_we;

    // Output stage: main register plus skid entry.
    logic       m_valid_reg;
    logic [7:0] m_data_reg;
    logic [3:0] m_user_reg;
    logic       skid_valid_reg;
    logic [7:0] skid_data_reg;
    logic [3:0] skid_user_reg;

    logic       accept;
    logic [1:0] cmd;
    logic [7:0] in_byte;
    logic       done_now;
    logic       wants_now;
    logic       wants_next;
    logic       done_next;
    logic       res_valid;
    logic [7:0] res_byte;
    logic       res_misuse;
    logic [3:0] res_user;
    logic [AW1-1:0]    bref_dist_w;
    logic [AW1-1:0]    wp_w;
    logic [DIST_W-1:0] dist_new;
    logic [PAT_AW-1:0] pat_pos_inc;
    logic              out_take;

    assign cmd     = s_axis_tuser;
    assign in_byte = s_axis_tdata;

    assign s_axis_tready = !skid_valid_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_take      = m_valid_reg && m_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    assign done_now  = emitted_reg >= output_size_reg;
    assign wants_now = (phase_reg != PH_RUN_EMIT) && (phase_reg != PH_BREF_EMIT)
                       && (phase_reg != PH_PAT_EMIT);

    // History read data with forwarding of a write to the entry being read.
    assign hist_rd = hist_fwd_hit_reg ? hist_fwd_data_reg : hist_rdata_reg;

    // Start of a back-reference: distance and the first read address.
    assign dist_new    = DIST_W'({token_reg[1:0], in_byte}) + DIST_W'(1);
    assign bref_dist_w = AW1'(dist_new);
    assign wp_w        = AW1'(write_pos_reg);

    assign pat_pos_inc = pat_pos_reg + PAT_AW'(1);

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            case (cmd)
                CMD_START:
                begin
                    phase_next = PH_TOKEN;
                end
                CMD_PUSH:
                begin
                    if (!done_now && wants_now)
                    begin
                        case (phase_reg)
                            PH_TOKEN:
                            begin
                                if (in_byte[TOK_KIND_HI])
                                begin
                                    if (in_byte[TOK_KIND_LO])
                                        phase_next = in_byte[TOK_EXT] ? PH_RUN_EXT : PH_RUN_BYTE;
                                    else
                                        phase_next = PH_BREF_LOW;
                                end
                                else if (in_byte[TOK_KIND_LO])
                                    phase_next = PH_PAT_COUNT;
                                else
                                    phase_next = in_byte[TOK_EXT] ? PH_LIT_EXT : PH_LIT_BYTES;
                            end
                            PH_LIT_EXT:   phase_next = PH_LIT_BYTES;
                            PH_LIT_BYTES:
                            begin
                                if (remaining_reg == REM_W'(1))
                                    phase_next = PH_TOKEN;
                            end
                            PH_RUN_EXT:   phase_next = PH_RUN_BYTE;
                            PH_RUN_BYTE:  phase_next = PH_RUN_EMIT;
                            PH_BREF_LOW:  phase_next = PH_BREF_EMIT;
                            PH_PAT_COUNT: phase_next = PH_PAT_BYTES;
                            PH_PAT_BYTES:
                            begin
                                if (pat_pos_inc >= pat_len_reg)
                                    phase_next = PH_PAT_EMIT;
                            end
                            default:      phase_next = PH_TOKEN;
                        endcase
                    end
                end
                CMD_STEP:
                begin
                    if (!done_now && !wants_now)
                    begin
                        case (phase_reg)
                            PH_RUN_EMIT, PH_BREF_EMIT:
                            begin
                                if (remaining_reg == REM_W'(1))
                                    phase_next = PH_TOKEN;
                            end
                            PH_PAT_EMIT:
                            begin
                                if ((pat_pos_inc >= pat_len_reg) && (repeats_reg == REP_W'(1)))
                                    phase_next = PH_TOKEN;
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Datapath registers, memory writes and the result of the item.
    always_comb
    begin
        write_pos_next = write_pos_reg;
        rd_ptr_next    = rd_ptr_reg;
        emitted_next   = emitted_reg;
        token_next     = token_reg;
        remaining_next = remaining_reg;
        repeats_next   = repeats_reg;
        pat_len_next   = pat_len_reg;
        distance_next  = distance_reg;
        run_byte_next  = run_byte_reg;
        pat_pos_next   = pat_pos_reg;
        hist_we        = 1'b0;
        hist_wdata     = in_byte;
        pat_we         = 1'b0;
        res_valid      = 1'b0;
        res_byte       = 8'd0;
        res_misuse     = 1'b0;

        if (accept)
        begin
            case (cmd)
                CMD_START:
                begin
                    write_pos_next = '0;
                    rd_ptr_next    = '0;
                    emitted_next   = '0;
                    token_next     = '0;
                    remaining_next = '0;
                    repeats_next   = '0;
                    pat_len_next   = '0;
                    distance_next  = '0;
                    run_byte_next  = '0;
                    pat_pos_next   = '0;
                end
                CMD_PUSH:
                begin
                    if (done_now || !wants_now)
                        res_misuse = 1'b1;
                    else
                    begin
                        case (phase_reg)
                            PH_TOKEN:
                            begin
                                token_next = in_byte;
                                if (in_byte[TOK_KIND_HI])
                                begin
                                    if (in_byte[TOK_KIND_LO])
                                        remaining_next = REM_W'(in_byte[4:0]) + REM_W'(2);
                                    else
                                        remaining_next = REM_W'(in_byte[5:2]) + REM_W'(2);
                                end
                                else if (in_byte[TOK_KIND_LO])
                                    pat_len_next = PLEN_W'(in_byte[5:0]) + PLEN_W'(2);
                                else
                                    remaining_next = REM_W'(in_byte[4:0]) + REM_W'(1);
                            end
                            PH_LIT_EXT, PH_RUN_EXT:
                            begin
                                remaining_next = remaining_reg + {1'b0, in_byte, 5'b00000};
                            end
                            PH_LIT_BYTES:
                            begin
                                hist_we        = 1'b1;
                                res_valid      = 1'b1;
                                res_byte       = in_byte;
                                remaining_next = remaining_reg - REM_W'(1);
                            end
                            PH_RUN_BYTE:
                            begin
                                run_byte_next = in_byte;
                            end
                            PH_BREF_LOW:
                            begin
                                distance_next = dist_new;
                                if (wp_w >= bref_dist_w)
                                    rd_ptr_next = AW'(wp_w - bref_dist_w);
                                else
                                    rd_ptr_next = AW'(wp_w + DEPTH_W - bref_dist_w);
                            end
                            PH_PAT_COUNT:
                            begin
                                repeats_next = REP_W'(in_byte) + REP_W'(1);
                                pat_pos_next = '0;
                            end
                            PH_PAT_BYTES:
                            begin
                                pat_we       = 1'b1;
                                pat_pos_next = (pat_pos_inc >= pat_len_reg) ? '0 : pat_pos_inc;
                            end
                            default:
                            begin
                                token_next = token_reg;
                            end
                        endcase
                    end
                end
                CMD_STEP:
                begin
                    if (done_now || wants_now)
                        res_misuse = 1'b1;
                    else
                    begin
                        hist_we   = 1'b1;
                        res_valid = 1'b1;
                        case (phase_reg)
                            PH_RUN_EMIT:
                            begin
                                res_byte       = run_byte_reg;
                                remaining_next = remaining_reg - REM_W'(1);
                            end
                            PH_BREF_EMIT:
                            begin
                                // A reference reaching before the stream start reads zero.
                                res_byte       = (32'(distance_reg) <= emitted_reg) ? hist_rd : 8'd0;
                                remaining_next = remaining_reg - REM_W'(1);
                            end
                            default:
                            begin
                                res_byte = pat_rdata_reg;
                                if (pat_pos_inc >= pat_len_reg)
                                begin
                                    pat_pos_next = '0;
                                    repeats_next = repeats_reg - REP_W'(1);
                                end
                                else
                                    pat_pos_next = pat_pos_inc;
                            end
                        endcase
                        hist_wdata = res_byte;
                    end
                end
                default:
                begin
                    res_misuse = 1'b1;
                end
            endcase

            // Every produced byte advances the history write and read pointers.
            if (hist_we)
            begin
                write_pos_next = (write_pos_reg == LAST_POS) ? '0 : write_pos_reg + AW'(1);
                rd_ptr_next    = (rd_ptr_reg == LAST_POS) ? '0 : rd_ptr_reg + AW'(1);
                emitted_next   = emitted_reg + 32'd1;
            end
        end
    end

    assign done_next  = emitted_next >= output_size_reg;
    assign wants_next = (phase_next != PH_RUN_EMIT) && (phase_next != PH_BREF_EMIT)
                        && (phase_next != PH_PAT_EMIT);
    assign res_user   = {res_misuse, done_next, !done_next && wants_next, res_valid};

    // Control and decoder state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_size_reg <= '0;
            write_pos_reg   <= '0;
            rd_ptr_reg      <= '0;
            emitted_reg     <= '0;
            phase_reg       <= PH_TOKEN;
            token_reg       <= '0;
            remaining_reg   <= '0;
            repeats_reg     <= '0;
            pat_len_reg     <= '0;
            distance_reg    <= '0;
            run_byte_reg    <= '0;
            pat_pos_reg     <= '0;
            m_valid_reg     <= 1'b0;
            skid_valid_reg  <= 1'b0;
            hist_fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                output_size_reg <= cfg_wdata;
            write_pos_reg <= write_pos_next;
            rd_ptr_reg    <= rd_ptr_next;
            emitted_reg   <= emitted_next;
            phase_reg     <= phase_next;
            token_reg     <= token_next;
            remaining_reg <= remaining_next;
            repeats_reg   <= repeats_next;
            pat_len_reg   <= pat_len_next;
            distance_reg  <= distance_next;
            run_byte_reg  <= run_byte_next;
            pat_pos_reg   <= pat_pos_next;
            hist_fwd_hit_reg <= hist_we && (write_pos_reg == rd_ptr_next);

            if (!m_valid_reg || out_take)
            begin
                m_valid_reg    <= skid_valid_reg || accept;
                skid_valid_reg <= 1'b0;
            end
            else if (accept)
                skid_valid_reg <= 1'b1;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        hist_fwd_data_reg <= hist_wdata;
        if (!m_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                m_data_reg <= skid_data_reg;
                m_user_reg <= skid_user_reg;
            end
            else
            begin
                m_data_reg <= res_byte;
                m_user_reg <= res_user;
            end
        end
        else if (accept)
        begin
            skid_data_reg <= res_byte;
            skid_user_reg <= res_user;
        end
    end

    // History memory: registered read, made ahead at the next step's address.
    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[write_pos_reg] <= hist_wdata;
        hist_rdata_reg <= hist_mem[rd_ptr_next];
    end

    // Pattern memory: registered read, made ahead at the next pattern position.
    always_ff @(posedge clk)
    begin
        if (pat_we)
            pat_mem[pat_pos_reg] <= in_byte;
        pat_rdata_reg <= pat_mem[pat_pos_next];
    end

    // The skid entry is only ever filled behind a held main entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry full while output register empty");

    // A result that carries a byte was never a rejected command.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(m_user_reg[0] && m_user_reg[3]))
        else $error("result both carries a byte and flags misuse");

    // Once done, no further byte is requested.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(m_user_reg[1] && m_user_reg[2]))
        else $error("want_byte raised after decoding finished");

    // Run and copy phases always have a byte left to produce.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_RUN_EMIT || phase_reg == PH_BREF_EMIT) |-> remaining_reg != '0)
        else $error("emit phase with empty byte count");

    // Pattern repeats keep the position inside the pattern and a repeat left.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAT_EMIT) |-> (pat_pos_reg < pat_len_reg && repeats_reg != '0))
        else $error("pattern position or repeat count out of range");

    // A produced byte moves the history pointer by one place.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && hist_we && cmd != CMD_START) |=> write_pos_reg != $past(write_pos_reg))
        else $error("history write pointer did not advance");

endmodule
